@@ sv/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Stream layout, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int FIELD_BITS = 32;
    localparam int IN_BITS    = 136;
    localparam int OUT_BITS   = 72;

    localparam int F_MODE_LSB = 0;
    localparam int F_ANUM_LSB = 3;
    localparam int F_ADEN_LSB = 35;
    localparam int F_BNUM_LSB = 67;
    localparam int F_BDEN_LSB = 99;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_ADD = 3'd0;
    localparam mode_t MODE_SUB = 3'd1;
    localparam mode_t MODE_MUL = 3'd2;
    localparam mode_t MODE_DIV = 3'd3;
    localparam mode_t MODE_NEG = 3'd4;
    localparam mode_t MODE_INC = 3'd5;
    localparam mode_t MODE_DEC = 3'd6;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_ZDEN = 2'd1;
    localparam status_t ST_DIVZ = 2'd2;
    localparam status_t ST_OVF  = 2'd3;

    typedef logic [1:0] rsel_t;
    localparam rsel_t RSEL_A = 2'd0;
    localparam rsel_t RSEL_B = 2'd1;
    localparam rsel_t RSEL_R = 2'd2;

    typedef logic [1:0] mulx_t;
    localparam mulx_t MX_AN = 2'd0;
    localparam mulx_t MX_AD = 2'd1;
    localparam mulx_t MX_BN = 2'd2;

    typedef logic [1:0] muly_t;
    localparam muly_t MY_BD = 2'd0;
    localparam muly_t MY_BN = 2'd1;
    localparam muly_t MY_AD = 2'd2;

    typedef logic [1:0] muld_t;
    localparam muld_t MD_T1 = 2'd0;
    localparam muld_t MD_T2 = 2'd1;
    localparam muld_t MD_RD = 2'd2;

    typedef logic [2:0] form_t;
    localparam form_t FORM_ADD  = 3'd0;
    localparam form_t FORM_SUB  = 3'd1;
    localparam form_t FORM_T1   = 3'd2;
    localparam form_t FORM_NEG  = 3'd3;
    localparam form_t FORM_INC  = 3'd4;
    localparam form_t FORM_DEC  = 3'd5;
    localparam form_t FORM_PASS = 3'd6;

    typedef struct packed {
        logic    load;
        logic    red_start;
        rsel_t   red_sel;
        logic    mul_en;
        mulx_t   mul_x;
        muly_t   mul_y;
        muld_t   mul_dst;
        logic    form_en;
        form_t   form_op;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  a_den_zero;
        logic  b_den_zero;
        logic  b_num_zero;
        logic  fits;
        logic  red_done;
    } stat_t;

endpackage

@@ sv/rau_reduce.sv @@
// ----------------------------------------------------------------------------
// Fraction reduction unit
// Finds the gcd of two magnitudes with a binary gcd, one step per cycle,
// then divides both magnitudes by it with two restoring dividers in step.
// ----------------------------------------------------------------------------
module rau_reduce #(
    parameter int DW = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] n_in,
    input  logic [DW-1:0] d_in,
    output logic [DW-1:0] n_out,
    output logic [DW-1:0] d_out,
    output logic          done
);

    localparam int KW = $clog2(DW);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_GCD  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [DW-1:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [KW-1:0] k_reg, k_next, cnt_reg, cnt_next;
    logic [DW-1:0] nq_reg, nq_next, dq_reg, dq_next;
    logic [DW-1:0] nr_reg, nr_next, dr_reg, dr_next;
    logic          done_reg, done_next;
    logic [DW:0]   n_sh, d_sh, n_dif, d_dif;

    always_comb begin
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        nq_next    = nq_reg;
        dq_next    = dq_reg;
        nr_next    = nr_reg;
        dr_next    = dr_reg;
        done_next  = 1'b0;
        n_sh       = {nr_reg, nq_reg[DW-1]};
        d_sh       = {dr_reg, dq_reg[DW-1]};
        n_dif      = n_sh - {1'b0, g_reg};
        d_dif      = d_sh - {1'b0, g_reg};
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    x_next     = n_in;
                    y_next     = d_in;
                    k_next     = '0;
                    nq_next    = n_in;
                    dq_next    = d_in;
                    phase_next = PH_GCD;
                end
            end
            PH_GCD: begin
                if (x_reg == '0) begin
                    g_next     = y_reg << k_reg;
                    nr_next    = '0;
                    dr_next    = '0;
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end
            PH_DIV: begin
                if (!n_dif[DW]) begin
                    nr_next = n_dif[DW-1:0];
                    nq_next = {nq_reg[DW-2:0], 1'b1};
                end else begin
                    nr_next = n_sh[DW-1:0];
                    nq_next = {nq_reg[DW-2:0], 1'b0};
                end
                if (!d_dif[DW]) begin
                    dr_next = d_dif[DW-1:0];
                    dq_next = {dq_reg[DW-2:0], 1'b1};
                end else begin
                    dr_next = d_sh[DW-1:0];
                    dq_next = {dq_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == KW'(DW - 1)) begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        g_reg   <= g_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        nq_reg  <= nq_next;
        dq_reg  <= dq_next;
        nr_reg  <= nr_next;
        dr_reg  <= dr_next;
    end

    assign n_out = nq_reg;
    assign d_out = dq_reg;
    assign done  = done_reg;

endmodule

@@ sv/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand and result registers in sign and magnitude form, one multiplier,
// the sign and magnitude adder, the reduction unit and the output register.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int W = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rau_pkg::IN_BITS-1:0]   in_data,
    input  rau_pkg::cmd_t                 cmd,
    output rau_pkg::stat_t                stat,
    output logic [rau_pkg::OUT_BITS-1:0]  out_data
);

    import rau_pkg::*;

    localparam int DW = 2 * W;
    localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic [DW:0] sm_add(input logic an, input logic [DW-1:0] am,
                                           input logic bn, input logic [DW-1:0] bm);
        logic          neg;
        logic [DW-1:0] mag;
        if (an == bn) begin
            neg = an;
            mag = am + bm;
        end else if (am >= bm) begin
            neg = an;
            mag = am - bm;
        end else begin
            neg = bn;
            mag = bm - am;
        end
        sm_add = {neg && (mag != '0), mag};
    endfunction

    logic [W-1:0]   an_f, ad_f, bn_f, bd_f;
    mode_t          mode_reg;
    logic           an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W-1:0]   an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic           t1_neg_reg, t2_neg_reg, rn_neg_reg, rd_neg_reg;
    logic [DW-1:0]  t1_mag_reg, t2_mag_reg, rn_mag_reg, rd_mag_reg;
    rsel_t          red_sel_reg;
    logic [DW-1:0]  red_n_in, red_d_in, red_n, red_d;
    logic           red_done;
    logic [W-1:0]   mx, my;
    logic           sx, sy;
    logic [DW-1:0]  prod;
    logic           pneg;
    logic [DW:0]    form_rn;
    logic           form_rd;
    logic           fits_n, fits_d;
    logic signed [W-1:0] rn_w, rd_w;
    logic [FIELD_BITS-1:0] num_reg, den_reg;
    status_t        status_reg;

    assign an_f = in_data[F_ANUM_LSB +: W];
    assign ad_f = in_data[F_ADEN_LSB +: W];
    assign bn_f = in_data[F_BNUM_LSB +: W];
    assign bd_f = in_data[F_BDEN_LSB +: W];

    always_comb begin
        case (cmd.red_sel)
            RSEL_A: begin
                red_n_in = DW'(an_mag_reg);
                red_d_in = DW'(ad_mag_reg);
            end
            RSEL_B: begin
                red_n_in = DW'(bn_mag_reg);
                red_d_in = DW'(bd_mag_reg);
            end
            default: begin
                red_n_in = rn_mag_reg;
                red_d_in = rd_mag_reg;
            end
        endcase
    end

    rau_reduce #(.DW(DW)) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.red_start),
        .n_in    (red_n_in),
        .d_in    (red_d_in),
        .n_out   (red_n),
        .d_out   (red_d),
        .done    (red_done)
    );

    always_comb begin
        case (cmd.mul_x)
            MX_AN: begin
                mx = an_mag_reg;
                sx = an_neg_reg;
            end
            MX_AD: begin
                mx = ad_mag_reg;
                sx = ad_neg_reg;
            end
            default: begin
                mx = bn_mag_reg;
                sx = bn_neg_reg;
            end
        endcase
        case (cmd.mul_y)
            MY_BD: begin
                my = bd_mag_reg;
                sy = bd_neg_reg;
            end
            MY_BN: begin
                my = bn_mag_reg;
                sy = bn_neg_reg;
            end
            default: begin
                my = ad_mag_reg;
                sy = ad_neg_reg;
            end
        endcase
    end

    assign prod = DW'(mx) * DW'(my);
    assign pneg = (sx ^ sy) && (prod != '0);

    always_comb begin
        form_rd = 1'b0;
        case (cmd.form_op)
            FORM_ADD: form_rn = sm_add(t1_neg_reg, t1_mag_reg, t2_neg_reg, t2_mag_reg);
            FORM_SUB: form_rn = sm_add(t1_neg_reg, t1_mag_reg, !t2_neg_reg, t2_mag_reg);
            FORM_T1:  form_rn = {t1_neg_reg, t1_mag_reg};
            FORM_NEG: begin
                form_rn = {!an_neg_reg && (an_mag_reg != '0), DW'(an_mag_reg)};
                form_rd = 1'b1;
            end
            FORM_INC: begin
                form_rn = sm_add(an_neg_reg, DW'(an_mag_reg), ad_neg_reg, DW'(ad_mag_reg));
                form_rd = 1'b1;
            end
            FORM_DEC: begin
                form_rn = sm_add(an_neg_reg, DW'(an_mag_reg), !ad_neg_reg, DW'(ad_mag_reg));
                form_rd = 1'b1;
            end
            default: begin
                form_rn = {an_neg_reg, DW'(an_mag_reg)};
                form_rd = 1'b1;
            end
        endcase
    end

    assign fits_n = rn_neg_reg ? (rn_mag_reg <= LIM) : (rn_mag_reg < LIM);
    assign fits_d = rd_neg_reg ? (rd_mag_reg <= LIM) : (rd_mag_reg < LIM);
    assign rn_w = rn_neg_reg ? (~rn_mag_reg[W-1:0] + W'(1)) : rn_mag_reg[W-1:0];
    assign rd_w = rd_neg_reg ? (~rd_mag_reg[W-1:0] + W'(1)) : rd_mag_reg[W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_data[F_MODE_LSB +: 3];
            an_neg_reg <= an_f[W-1];
            ad_neg_reg <= ad_f[W-1];
            bn_neg_reg <= bn_f[W-1];
            bd_neg_reg <= bd_f[W-1];
            an_mag_reg <= mag_of(an_f);
            ad_mag_reg <= mag_of(ad_f);
            bn_mag_reg <= mag_of(bn_f);
            bd_mag_reg <= mag_of(bd_f);
        end
        if (cmd.red_start) begin
            red_sel_reg <= cmd.red_sel;
        end
        if (red_done) begin
            case (red_sel_reg)
                RSEL_A: begin
                    an_mag_reg <= red_n[W-1:0];
                    ad_mag_reg <= red_d[W-1:0];
                end
                RSEL_B: begin
                    bn_mag_reg <= red_n[W-1:0];
                    bd_mag_reg <= red_d[W-1:0];
                end
                default: begin
                    rn_mag_reg <= red_n;
                    rd_mag_reg <= red_d;
                end
            endcase
        end
        if (cmd.mul_en) begin
            case (cmd.mul_dst)
                MD_T1: begin
                    t1_neg_reg <= pneg;
                    t1_mag_reg <= prod;
                end
                MD_T2: begin
                    t2_neg_reg <= pneg;
                    t2_mag_reg <= prod;
                end
                default: begin
                    rd_neg_reg <= pneg;
                    rd_mag_reg <= prod;
                end
            endcase
        end
        if (cmd.form_en) begin
            rn_neg_reg <= form_rn[DW];
            rn_mag_reg <= form_rn[DW-1:0];
            if (form_rd) begin
                rd_neg_reg <= ad_neg_reg;
                rd_mag_reg <= DW'(ad_mag_reg);
            end
        end
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            if (cmd.out_status == ST_OK) begin
                num_reg <= FIELD_BITS'(rn_w);
                den_reg <= FIELD_BITS'(rd_w);
            end else begin
                num_reg <= '0;
                den_reg <= '0;
            end
        end
    end

    always_comb begin
        stat.mode       = mode_reg;
        stat.a_den_zero = (ad_mag_reg == '0);
        stat.b_den_zero = (bd_mag_reg == '0);
        stat.b_num_zero = (bn_mag_reg == '0);
        stat.fits       = fits_n && fits_d;
        stat.red_done   = red_done;
    end

    assign out_data = {{(OUT_BITS - 2 - 2 * FIELD_BITS){1'b0}}, status_reg, den_reg, num_reg};

endmodule

@@ sv/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences checks, reductions, products and the final form of one item,
// and owns both stream handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  rau_pkg::stat_t  stat,
    output rau_pkg::cmd_t   cmd
);

    import rau_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_WAIT_A = 4'd2;
    localparam logic [3:0] S_WAIT_B = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_MUL3   = 4'd6;
    localparam logic [3:0] S_FORM   = 4'd7;
    localparam logic [3:0] S_RED_R  = 4'd8;
    localparam logic [3:0] S_WAIT_R = 4'd9;
    localparam logic [3:0] S_FIT    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;
    status_t    st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       binary;

    assign binary = stat.mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.a_den_zero || (binary && stat.b_den_zero)) begin
                    st_next    = ST_ZDEN;
                    state_next = S_DONE;
                end else begin
                    st_next       = ST_OK;
                    cmd.red_start = 1'b1;
                    cmd.red_sel   = RSEL_A;
                    state_next    = S_WAIT_A;
                end
            end
            S_WAIT_A: begin
                if (stat.red_done) begin
                    if (binary) begin
                        cmd.red_start = 1'b1;
                        cmd.red_sel   = RSEL_B;
                        state_next    = S_WAIT_B;
                    end else begin
                        state_next = S_FORM;
                    end
                end
            end
            S_WAIT_B: begin
                if (stat.red_done) begin
                    if (stat.mode == MODE_DIV && stat.b_num_zero) begin
                        st_next    = ST_DIVZ;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_x   = MX_AN;
                cmd.mul_dst = MD_T1;
                cmd.mul_y   = (stat.mode == MODE_MUL) ? MY_BN : MY_BD;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_en = 1'b1;
                case (stat.mode)
                    MODE_ADD, MODE_SUB: begin
                        cmd.mul_x   = MX_BN;
                        cmd.mul_y   = MY_AD;
                        cmd.mul_dst = MD_T2;
                        state_next  = S_MUL3;
                    end
                    MODE_DIV: begin
                        cmd.mul_x   = MX_AD;
                        cmd.mul_y   = MY_BN;
                        cmd.mul_dst = MD_RD;
                        state_next  = S_FORM;
                    end
                    default: begin
                        cmd.mul_x   = MX_AD;
                        cmd.mul_y   = MY_BD;
                        cmd.mul_dst = MD_RD;
                        state_next  = S_FORM;
                    end
                endcase
            end
            S_MUL3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_x   = MX_AD;
                cmd.mul_y   = MY_BD;
                cmd.mul_dst = MD_RD;
                state_next  = S_FORM;
            end
            S_FORM: begin
                cmd.form_en = 1'b1;
                case (stat.mode)
                    MODE_ADD: cmd.form_op = FORM_ADD;
                    MODE_SUB: cmd.form_op = FORM_SUB;
                    MODE_MUL, MODE_DIV: cmd.form_op = FORM_T1;
                    MODE_NEG: cmd.form_op = FORM_NEG;
                    MODE_INC: cmd.form_op = FORM_INC;
                    MODE_DEC: cmd.form_op = FORM_DEC;
                    default:  cmd.form_op = FORM_PASS;
                endcase
                state_next = S_RED_R;
            end
            S_RED_R: begin
                cmd.red_start = 1'b1;
                cmd.red_sel   = RSEL_R;
                state_next    = S_WAIT_R;
            end
            S_WAIT_R: begin
                if (stat.red_done) begin
                    state_next = S_FIT;
                end
            end
            S_FIT: begin
                st_next    = stat.fits ? ST_OK : ST_OVF;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ sv/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates, increments or decrements
// fractions and returns the result reduced by the gcd, with a status code.
//
// Channel   Direction  Payload
// s_*       in         mode, a_num, a_den, b_num, b_den
// m_*       out        res_num, res_den, status
//
// One item is in work at a time. The shared gcd and divide unit runs once per
// operand and once for the result: one gcd step and one quotient bit a cycle.
// A new item is taken while the previous result waits in the output register.
// Reset is synchronous and active low and clears only control state.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zeros
    input  logic [rau_pkg::IN_BITS-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // res_num[31:0], res_den[63:32], status[65:64], zeros
    output logic [rau_pkg::OUT_BITS-1:0]  m_tdata
);

    import rau_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rau_datapath #(.W(WORD_BITS)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule

@@ sv/rau_checker.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port level properties of the input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rau_pkg::OUT_BITS-1:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer dropped while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] != 2'd0) |-> (m_tdata[63:0] == 64'd0))
        else $error("error result carries a nonzero fraction");

    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] == 2'd0) |-> (m_tdata[63:32] != 32'd0))
        else $error("good result has a zero denominator");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:66] == 6'd0))
        else $error("result padding bits are not zero");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
